@@ rtl/slip_rx_pkg.sv @@
// Shared types and constants for the SLIP receive deframer and packet ring.
// No dependencies; imported by the core, the checker and the testbench.
package slip_rx_pkg;

  localparam int SLOT_COUNT_DEF  = 8;
  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [7:0] END_CODE = 8'hC0;
  localparam logic [7:0] ESC_CODE = 8'hDB;

  localparam logic [1:0] OP_LINE    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] line_byte;
    logic [5:0] read_offset;
  } cmd_t;

  typedef struct packed {
    logic       packet_available;
    logic [7:0] read_data;
    logic       frame_committed;
    logic       frame_discarded;
    logic       byte_truncated;
  } result_t;

endpackage

@@ rtl/slip_rx_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for the packet slot store.
module slip_rx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 264
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/slip_receive_packet_ring_core.sv @@
// Top level: SLIP receive deframer writing into a ring of fixed-size packet slots.
// Depends on slip_rx_pkg and slip_rx_ram.
//
//   channel | signals           | handshake
//   --------+-------------------+------------------------------------------
//   command | start, cmd        | beat taken when start && !busy
//   result  | done, result      | one beat per command, valid for done cycle
//
// Each command's result passes through the input register, then the state update
// and the slot store's registered read.
// A new command can be taken every cycle while busy is low.
// After reset, busy stays high while all SLOT_COUNT*(MAX_PAYLOAD+1) bytes (264 with
// defaults) of the slot store are swept to zero.
// The receiver cannot stall; results are never held.
module slip_receive_packet_ring_core
  import slip_rx_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  localparam int SLOT_BYTES  = MAX_PAYLOAD + 1;
  localparam int STORE_BYTES = SLOT_COUNT * SLOT_BYTES;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FILL_W      = $clog2(SLOT_BYTES + 1);
  localparam int XW          = (ADDR_W > 6) ? ADDR_W : 6;

  // clearing sweep
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // input register
  logic in_v;
  cmd_t in_q;

  // ring state
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [ADDR_W-1:0] write_base, write_base_next;
  logic [ADDR_W-1:0] read_base, read_base_next;
  logic [FILL_W-1:0] fill_position, fill_position_next;
  logic              escape_pending, escape_pending_next;

  // result register
  logic res_v;
  logic avail_q, committed_q, discarded_q, truncated_q, rd_ok_q;

  // stage logic
  logic              st_we, rd_ok;
  logic              committed, discarded, truncated;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic              has_pkt, fill_room, offset_ok;
  logic [SLOT_W-1:0] wr_slot_inc, rd_slot_inc;
  logic [ADDR_W-1:0] wr_base_inc, rd_base_inc;
  logic [XW-1:0]     rd_sum;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign busy = clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    if (start && !busy) begin
      in_q <= cmd;
    end
  end

  // wrap helpers for slot index and its base address
  assign has_pkt     = (read_slot != write_slot);
  assign fill_room   = ({1'b0, fill_position} < (FILL_W + 1)'(SLOT_BYTES));
  assign offset_ok   = (32'(in_q.read_offset) < 32'(SLOT_BYTES));
  assign wr_slot_inc = (write_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                               : write_slot + SLOT_W'(1);
  assign rd_slot_inc = (read_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                              : read_slot + SLOT_W'(1);
  assign wr_base_inc = (write_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                               : write_base + ADDR_W'(SLOT_BYTES);
  assign rd_base_inc = (read_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                              : read_base + ADDR_W'(SLOT_BYTES);
  assign rd_sum      = XW'(read_base) + XW'(in_q.read_offset);
  assign st_waddr    = write_base + ADDR_W'(fill_position);

  always_comb begin
    write_slot_next     = write_slot;
    read_slot_next      = read_slot;
    write_base_next     = write_base;
    read_base_next      = read_base;
    fill_position_next  = fill_position;
    escape_pending_next = escape_pending;
    st_we               = 1'b0;
    rd_ok               = 1'b0;
    st_raddr            = read_base;
    committed           = 1'b0;
    discarded           = 1'b0;
    truncated           = 1'b0;
    if (in_v) begin
      unique case (in_q.opcode)
        OP_LINE: begin
          if (escape_pending || (in_q.line_byte != ESC_CODE
                                 && in_q.line_byte != END_CODE)) begin
            escape_pending_next = 1'b0;
            if (fill_room) begin
              st_we              = 1'b1;
              fill_position_next = fill_position + FILL_W'(1);
            end else begin
              truncated = 1'b1;
            end
          end else if (in_q.line_byte == ESC_CODE) begin
            escape_pending_next = 1'b1;
          end else begin
            // end byte: close frame, commit if the ring has room
            fill_position_next = '0;
            if (wr_slot_inc != read_slot) begin
              write_slot_next = wr_slot_inc;
              write_base_next = wr_base_inc;
              committed       = 1'b1;
            end else begin
              discarded = 1'b1;
            end
          end
        end
        OP_READ: begin
          rd_ok = has_pkt && offset_ok;
          if (rd_ok) begin
            st_raddr = rd_sum[ADDR_W-1:0];
          end
        end
        OP_RELEASE: begin
          if (has_pkt) begin
            read_slot_next = rd_slot_inc;
            read_base_next = rd_base_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      read_slot      <= '0;
      write_base     <= '0;
      read_base      <= '0;
      fill_position  <= '0;
      escape_pending <= 1'b0;
      res_v          <= 1'b0;
    end else begin
      write_slot     <= write_slot_next;
      read_slot      <= read_slot_next;
      write_base     <= write_base_next;
      read_base      <= read_base_next;
      fill_position  <= fill_position_next;
      escape_pending <= escape_pending_next;
      res_v          <= in_v;
    end
    avail_q     <= (read_slot_next != write_slot_next);
    committed_q <= committed;
    discarded_q <= discarded;
    truncated_q <= truncated;
    rd_ok_q     <= rd_ok;
  end

  assign ram_we    = clr_active || st_we;
  assign ram_waddr = clr_active ? clr_addr : st_waddr;
  assign ram_wdata = clr_active ? 8'h00 : in_q.line_byte;

  slip_rx_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (st_raddr),
    .rdata (ram_rdata)
  );

  assign done                    = res_v;
  assign result.packet_available = avail_q;
  assign result.read_data        = rd_ok_q ? ram_rdata : 8'h00;
  assign result.frame_committed  = committed_q;
  assign result.frame_discarded  = discarded_q;
  assign result.byte_truncated   = truncated_q;

endmodule

@@ rtl/slip_rx_checker.sv @@
// Port-level checks for slip_receive_packet_ring_core, attached by bind.
// Depends on slip_rx_pkg.
module slip_rx_checker
  import slip_rx_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    done,
  input result_t result
);

  // one result per accepted command beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing two cycles after command beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without matching command beat");

  a_read_only_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_data != 8'h00) |-> ($past(cmd.opcode, 2) == OP_READ))
    else $error("read data on a non-read command");

  a_commit_avail: assert property (@(posedge clk) disable iff (rst)
    (done && result.frame_committed) |->
      (result.packet_available && !result.frame_discarded))
    else $error("commit without a waiting packet");

  a_busy_once: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(rst))
    else $error("busy rose outside reset");

endmodule

bind slip_receive_packet_ring_core slip_rx_checker u_chk (.*);

@@ tb/sv/slip_receive_packet_ring_core_tb.sv @@
// Testbench for slip_receive_packet_ring_core: directed and random command beats,
// checked beat by beat against an in-bench model of the deframer and packet ring.
// Depends on slip_rx_pkg and the RTL of the block.
`timescale 1ns / 100ps

module slip_receive_packet_ring_core_tb;
  import slip_rx_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int SLOT_BYTES  = MAX_PAYLOAD_DEF + 1;
  localparam int RANDOM_CMDS = 950;
  localparam int CMD_CAP     = 2048;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    cmd_t c;
    bit   drain;   // wait for every outstanding result before this beat
  } pending_cmd_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  pending_cmd_t pending_cmds[$];
  result_t      expected_status [CMD_CAP];
  int           n_predicted = 0;
  int           n_checked = 0;
  int           n_errors = 0;
  int           total_cmds = 0;
  int           cycles = 0;

  // model of the ring
  logic [7:0] ring_mem [SLOTS*SLOT_BYTES] = '{default: 8'h00};
  int         wr_slot = 0;
  int         rd_slot = 0;
  int         fill_pos = 0;
  bit         esc_armed = 1'b0;
  int         n_commits = 0, n_discards = 0, n_truncs = 0, n_reads = 0, n_releases = 0;

  slip_receive_packet_ring_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  function automatic result_t ring_step(cmd_t c);
    result_t r;
    r = '0;
    case (c.opcode)
      OP_LINE: begin
        if (!esc_armed && c.line_byte == ESC_CODE) begin
          esc_armed = 1'b1;
        end else if (!esc_armed && c.line_byte == END_CODE) begin
          fill_pos = 0;
          if ((wr_slot + 1) % SLOTS != rd_slot) begin
            wr_slot = (wr_slot + 1) % SLOTS;
            r.frame_committed = 1'b1;
            n_commits++;
          end else begin
            r.frame_discarded = 1'b1;
            n_discards++;
          end
        end else begin
          // plain data or the byte after an escape
          esc_armed = 1'b0;
          if (fill_pos < SLOT_BYTES) begin
            ring_mem[wr_slot*SLOT_BYTES + fill_pos] = c.line_byte;
            fill_pos++;
          end else begin
            r.byte_truncated = 1'b1;
            n_truncs++;
          end
        end
      end
      OP_READ: begin
        n_reads++;
        if (rd_slot != wr_slot && c.read_offset < SLOT_BYTES)
          r.read_data = ring_mem[rd_slot*SLOT_BYTES + c.read_offset];
      end
      OP_RELEASE: begin
        if (rd_slot != wr_slot) begin
          rd_slot = (rd_slot + 1) % SLOTS;
          n_releases++;
        end
      end
      default: ;
    endcase
    r.packet_available = (rd_slot != wr_slot);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                n_checked, name, got, want));
  endtask

  task automatic queue_cmd(logic [1:0] op, logic [7:0] b, logic [5:0] off);
    pending_cmd_t p;
    p.c.opcode      = op;
    p.c.line_byte   = b;
    p.c.read_offset = off;
    p.drain         = 1'b0;
    pending_cmds.push_back(p);
  endtask

  // driver: presents pending beats, predicts each accepted one
  always @(posedge clk) begin : drive_proc
    int took;
    int idle_pct;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = (start && !busy) ? 1 : 0;
      if (took != 0) begin
        expected_status[n_predicted] <= ring_step(cmd);
        n_predicted <= n_predicted + 1;
        void'(pending_cmds.pop_front());
      end
      idle_pct = (n_predicted < total_cmds / 3)     ? 20 :
                 (n_predicted < 2 * total_cmds / 3) ? 82 : 0;
      if (start && took == 0) begin
        // held while busy
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && n_predicted + took != n_checked) &&
                   $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        cmd   <= pending_cmds[0].c;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: one result beat per done cycle, compared in order
  always @(posedge clk) begin : monitor_proc
    result_t want;
    if (!rst && done) begin
      if (n_checked >= n_predicted) begin
        report_mismatch($sformatf("result beat with nothing expected: %p", result));
      end else begin
        want = expected_status[n_checked];
        check_field("packet_available", int'(result.packet_available),
                    int'(want.packet_available));
        check_field("read_data", int'(result.read_data), int'(want.read_data));
        check_field("frame_committed", int'(result.frame_committed),
                    int'(want.frame_committed));
        check_field("frame_discarded", int'(result.frame_discarded),
                    int'(want.frame_discarded));
        check_field("byte_truncated", int'(result.byte_truncated),
                    int'(want.byte_truncated));
      end
      n_checked <= n_checked + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen",
               cycles, n_checked, total_cmds);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stim_proc
    int n_directed;
    int pick, bias, len, esc_pct, n_rd;
    logic [7:0] b;

    // directed: empty ring, unused opcode, escapes, reads at the slot edges,
    // ring filling up until an end byte is discarded
    queue_cmd(OP_READ, 8'hFF, 6'd0);
    queue_cmd(OP_RELEASE, 8'h00, 6'd63);
    queue_cmd(OP_UNUSED, 8'hA5, 6'd21);
    queue_cmd(OP_LINE, 8'h00, 6'd0);
    queue_cmd(OP_LINE, 8'hFF, 6'd0);
    queue_cmd(OP_LINE, ESC_CODE, 6'd0);
    queue_cmd(OP_LINE, END_CODE, 6'd0);
    queue_cmd(OP_LINE, ESC_CODE, 6'd0);
    queue_cmd(OP_LINE, ESC_CODE, 6'd0);
    queue_cmd(OP_LINE, ESC_CODE, 6'd0);
    queue_cmd(OP_LINE, 8'h41, 6'd0);
    queue_cmd(OP_LINE, END_CODE, 6'd0);
    queue_cmd(OP_READ, 8'h00, 6'd0);
    queue_cmd(OP_READ, 8'h00, 6'd3);
    queue_cmd(OP_READ, 8'h00, 6'd32);
    queue_cmd(OP_READ, 8'h00, 6'd33);
    queue_cmd(OP_READ, 8'h00, 6'd63);
    repeat (7) queue_cmd(OP_LINE, END_CODE, 6'd0);  // six empty frames, then ring full
    queue_cmd(OP_RELEASE, 8'h00, 6'd0);
    n_directed = pending_cmds.size();

    // random: mostly well-formed frames and consumer bursts, some noise;
    // the producer/consumer balance swings so the ring fills and drains
    while (pending_cmds.size() < n_directed + RANDOM_CMDS) begin
      bias = ((pending_cmds.size() / 120) % 2 != 0) ? 30 : 70;
      pick = $urandom_range(99);
      if (pick < 12) begin
        queue_cmd(2'($urandom_range(3)), 8'($urandom), 6'($urandom));
      end else if (pick < 12 + bias * 88 / 100) begin
        len     = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 16);
        esc_pct = (len > 32) ? 30 : 12;
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          if ($urandom_range(99) < esc_pct || b == END_CODE || b == ESC_CODE) begin
            queue_cmd(OP_LINE, ESC_CODE, 6'($urandom));
            if ($urandom_range(3) == 0)
              b = $urandom_range(1) ? END_CODE : ESC_CODE;
          end
          queue_cmd(OP_LINE, b, 6'($urandom));
        end
        if ($urandom_range(19) != 0)
          queue_cmd(OP_LINE, END_CODE, 6'($urandom));
      end else begin
        n_rd = $urandom_range(1, 4);
        for (int i = 0; i < n_rd; i++)
          queue_cmd(OP_READ, 8'($urandom),
                    6'(($urandom_range(9) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(0, 32)));
        if ($urandom_range(9) < 7)
          queue_cmd(OP_RELEASE, 8'($urandom), 6'($urandom));
      end
    end
    pending_cmds[n_directed].drain = 1'b1;
    pending_cmds[pending_cmds.size() / 2].drain = 1'b1;
    total_cmds = pending_cmds.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (n_predicted == total_cmds && n_checked == n_predicted);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d command beats in %0d cycles: %0d reads, %0d releases taken",
             total_cmds, cycles, n_reads, n_releases);
    $display("Frames committed %0d, discarded on full ring %0d, bytes truncated %0d",
             n_commits, n_discards, n_truncs);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
